### rtl/sdcg_pkg.sv
// ----------------------------------------------------------------------------
// sdcg_pkg: shared types and tables of the scale degree chord generator
// Progression tables, chord quality interval tables and the structs that
// travel between the chord calculator and the top level.
// ----------------------------------------------------------------------------
package sdcg_pkg;

    localparam int NUM_PROG   = 22;
    localparam int NUM_DEG    = 7;
    localparam int MAX_NOTES  = 5;
    localparam int NUM_QUAL   = 8;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_PROGRESSION = 3'd0;
    localparam logic [2:0] REG_KEY_ROOT    = 3'd1;
    localparam logic [2:0] REG_VOICING     = 3'd2;
    localparam logic [2:0] REG_EXTENSION   = 3'd3;
    localparam logic [2:0] REG_OCTAVE      = 3'd4;

    // Voicing and extension codes.
    localparam logic [1:0] VOICE_CLOSE = 2'd0;
    localparam logic [1:0] VOICE_OPEN  = 2'd1;
    localparam logic [1:0] VOICE_DROP2 = 2'd2;
    localparam logic [1:0] EXT_TRIAD   = 2'd0;
    localparam logic [1:0] EXT_SEVENTH = 2'd1;
    localparam logic [1:0] EXT_NINTH   = 2'd2;

    // Progression flag bits.
    localparam int FLAG_QUARTAL = 0;
    localparam int FLAG_QUINTAL = 1;
    localparam int FLAG_CHROM   = 2;

    localparam logic [4:0] LAST_PROG  = 5'd21;
    localparam logic [3:0] LAST_KEY   = 4'd11;
    localparam logic [6:0] BASE_NOTE  = 7'd60;
    localparam logic [4:0] OCT_SEMIS  = 5'd12;
    localparam logic [4:0] NINTH_IVL  = 5'd14;

    localparam logic [2:0] PROG_COUNT [NUM_PROG] = '{
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd4, 3'd3, 3'd4, 3'd6, 3'd7, 3'd7,
        3'd6, 3'd7, 3'd3, 3'd4, 3'd7, 3'd7, 3'd5, 3'd4, 3'd4, 3'd6, 3'd4};

    localparam logic [2:0] PROG_FLAGS [NUM_PROG] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0};

    localparam logic [3:0] PROG_IVL [NUM_PROG][NUM_DEG] = '{
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd5, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd5, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd10, 4'd8, 4'd7, 4'd0, 4'd0, 4'd0},
        '{4'd9, 4'd2, 4'd7, 4'd0, 4'd5, 4'd11, 4'd0},
        '{4'd0, 4'd9, 4'd11, 4'd0, 4'd7, 4'd4, 4'd11},
        '{4'd0, 4'd3, 4'd4, 4'd6, 4'd7, 4'd10, 4'd11},
        '{4'd0, 4'd3, 4'd4, 4'd8, 4'd9, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd8, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd0},
        '{4'd0, 4'd11, 4'd10, 4'd9, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd4, 4'd5, 4'd7, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd11, 4'd4, 4'd9, 4'd2, 4'd0, 4'd0, 4'd0}};

    localparam logic [2:0] PROG_QUAL [NUM_PROG][NUM_DEG] = '{
        '{3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd1, 3'd2},
        '{3'd1, 3'd1, 3'd0, 3'd0, 3'd1, 3'd2, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd1, 3'd0},
        '{3'd1, 3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd1},
        '{3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd4, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd2, 3'd0},
        '{3'd0, 3'd4, 3'd4, 3'd4, 3'd0, 3'd4, 3'd2},
        '{3'd0, 3'd4, 3'd1, 3'd4, 3'd0, 3'd4, 3'd2},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0},
        '{3'd0, 3'd1, 3'd1, 3'd0, 3'd4, 3'd1, 3'd2},
        '{3'd5, 3'd5, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd7, 3'd1, 3'd7, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd2, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0}};

    // Amount by which the chromatic bass lowers the root, per degree.
    localparam logic [2:0] BASS_DROP [NUM_DEG] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0};

    // Third, fifth and seventh above the root, per chord quality.
    localparam logic [4:0] Q_THIRD [NUM_QUAL] = '{
        5'd4, 5'd3, 5'd3, 5'd4, 5'd4, 5'd4, 5'd3, 5'd3};
    localparam logic [4:0] Q_FIFTH [NUM_QUAL] = '{
        5'd7, 5'd7, 5'd6, 5'd8, 5'd7, 5'd7, 5'd7, 5'd6};
    localparam logic [4:0] Q_SEV [NUM_QUAL] = '{
        5'd11, 5'd10, 5'd10, 5'd11, 5'd10, 5'd11, 5'd10, 5'd9};

    localparam logic [4:0] QUARTAL_STACK [4] = '{5'd0, 5'd5, 5'd10, 5'd15};
    localparam logic [4:0] QUINTAL_STACK [4] = '{5'd0, 5'd7, 5'd14, 5'd21};

    // Configuration register set.
    typedef struct packed {
        logic [4:0] progression;
        logic [3:0] key_root;
        logic [1:0] voicing;
        logic [1:0] extension;
        logic [2:0] octave_shift;
    } cfg_t;

    // One finished chord: voiced notes and the note count (3 to 5).
    typedef struct packed {
        logic [MAX_NOTES-1:0][6:0] note;
        logic [2:0]                count;
    } chord_t;

endpackage

### rtl/sdcg_if.sv
// ----------------------------------------------------------------------------
// sdcg_if: valid/ready channels of the scale degree chord generator
// The degree channel carries requests in, the note channel carries chord
// tones out, one transaction per note.
// ----------------------------------------------------------------------------
interface sdcg_degree_if;
    logic       valid;
    logic       ready;
    logic [2:0] degree;

    modport source (output valid, output degree, input ready);
    modport sink (input valid, input degree, output ready);
endinterface

interface sdcg_note_if;
    logic       valid;
    logic       ready;
    logic [6:0] note;
    logic       last;

    modport source (output valid, output note, output last, input ready);
    modport sink (input valid, input note, input last, output ready);
endinterface

### rtl/sdcg_chord_calc.sv
// ----------------------------------------------------------------------------
// sdcg_chord_calc: chord construction for one scale degree
// Looks up interval and quality, builds the interval stack and applies the
// voicing, giving all chord notes at once.
// ----------------------------------------------------------------------------
module sdcg_chord_calc
(
    input  sdcg_pkg::cfg_t   cfg,
    input  logic [2:0]       degree,
    output sdcg_pkg::chord_t chord
);
    import sdcg_pkg::*;

    // Clamp a signed intermediate note into the MIDI range.
    function automatic logic [6:0] sat_note(input logic signed [8:0] v);
        logic [6:0] r;
        if (v < 9'sd0)
        begin
            r = 7'd0;
        end
        else if (v > 9'sd127)
        begin
            r = 7'd127;
        end
        else
        begin
            r = v[6:0];
        end
        return r;
    endfunction

    logic [4:0]              prog;
    logic [3:0]              key;
    logic signed [2:0]       oct;
    logic [2:0]              deg_max;
    logic [2:0]              deg;
    logic [2:0]              flags;
    logic [2:0]              qual;
    logic signed [8:0]       base;
    logic signed [8:0]       n [MAX_NOTES];
    logic signed [8:0]       v [MAX_NOTES];
    logic [2:0]              cnt;
    logic [2:0]              vc;

    // Saturate the registers and clamp the degree to the progression.
    always_comb
    begin
        prog    = (cfg.progression > LAST_PROG) ? LAST_PROG : cfg.progression;
        key     = (cfg.key_root > LAST_KEY) ? LAST_KEY : cfg.key_root;
        oct     = $signed(cfg.octave_shift);
        if (oct == -3'sd4)
        begin
            oct = -3'sd3;
        end
        else if (oct == 3'sd3)
        begin
            oct = 3'sd2;
        end
        deg_max = PROG_COUNT[prog] - 3'd1;
        deg     = (degree > deg_max) ? deg_max : degree;
        flags   = PROG_FLAGS[prog];
        qual    = PROG_QUAL[prog][deg];
        base    = $signed({2'b00, BASE_NOTE}) + $signed({5'b0, key})
                + $signed({5'b0, PROG_IVL[prog][deg]})
                + {{6{oct[2]}}, oct} * $signed({4'b0, OCT_SEMIS});
    end

    // Build the close-order stack and voice it.
    always_comb
    begin
        for (int i = 0; i < MAX_NOTES; i++)
        begin
            n[i] = base;
            v[i] = base;
        end
        cnt = 3'd3;
        vc  = 3'd3;
        if (flags[FLAG_QUARTAL] || flags[FLAG_QUINTAL])
        begin
            // Fixed stacks of fourths or fifths, no voicing.
            for (int i = 0; i < 4; i++)
            begin
                v[i] = base + $signed({4'b0, flags[FLAG_QUARTAL] ? QUARTAL_STACK[i]
                                                              : QUINTAL_STACK[i]});
            end
            vc = 3'd4;
        end
        else
        begin
            n[0] = base;
            n[1] = base + $signed({4'b0, Q_THIRD[qual]});
            n[2] = base + $signed({4'b0, Q_FIFTH[qual]});
            n[3] = base + $signed({4'b0, Q_SEV[qual]});
            n[4] = base + $signed({4'b0, NINTH_IVL});
            if (cfg.extension == EXT_SEVENTH)
            begin
                cnt = 3'd4;
            end
            else if (cfg.extension == EXT_NINTH)
            begin
                cnt = 3'd5;
            end
            if (flags[FLAG_CHROM])
            begin
                n[0] = base - $signed({6'b0, BASS_DROP[deg]});
            end

            if (cfg.voicing == VOICE_DROP2)
            begin
                v[0] = n[0];
                v[2] = n[1];
                unique case (cnt)
                    3'd4:
                    begin
                        v[1] = n[3];
                        v[3] = n[2] - $signed({4'b0, OCT_SEMIS});
                    end
                    3'd5:
                    begin
                        v[1] = n[4];
                        v[3] = n[3] - $signed({4'b0, OCT_SEMIS});
                    end
                    default:
                    begin
                        v[1] = n[2];
                        v[3] = n[2];
                    end
                endcase
                vc = 3'd4;
            end
            else
            begin
                for (int i = 0; i < MAX_NOTES; i++)
                begin
                    v[i] = n[i];
                end
                if (cfg.voicing == VOICE_OPEN)
                begin
                    v[1] = n[1] + $signed({4'b0, OCT_SEMIS});
                end
                vc = cnt;
            end
        end
    end

    // Pack the voiced notes.
    always_comb
    begin
        for (int i = 0; i < MAX_NOTES; i++)
        begin
            chord.note[i] = sat_note(v[i]);
        end
        chord.count = vc;
    end

endmodule

### rtl/scale_degree_chord_generator.sv
// ----------------------------------------------------------------------------
// scale_degree_chord_generator: scale degree to chord note stream
// Registers a degree, builds its chord in one pass and streams the notes,
// one transaction per note, with the final note marked by last.
// ----------------------------------------------------------------------------
// A degree transaction yields a chord of 3 to 5 notes, streamed one note per
// cycle from the chord register while chord.ready is high. The note count is
// 4 for quartal, quintal and drop2 chords, else 4 with the seventh, 5 with the
// ninth and 3 otherwise. The next degree is taken into the input register and
// its chord is built while the current chord is still being streamed, so the
// output runs without gaps. An accepted degree passes the input register, then
// the chord register, before its first note. Configuration writes take effect
// at once and must be made only while no chord is in flight.
module scale_degree_chord_generator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [4:0]          cfg_data,
    sdcg_degree_if.sink         req,
    sdcg_note_if.source         chord
);
    import sdcg_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [2:0] in_degree_reg;
    logic       chord_valid_reg;
    chord_t     chord_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    chord_t     chord_next;
    logic       is_last;
    logic       out_fire;
    logic       chord_done;
    logic       chord_load;
    logic       in_fire;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROGRESSION: cfg_reg.progression  <= cfg_data;
                REG_KEY_ROOT:    cfg_reg.key_root     <= cfg_data[3:0];
                REG_VOICING:     cfg_reg.voicing      <= cfg_data[1:0];
                REG_EXTENSION:   cfg_reg.extension    <= cfg_data[1:0];
                REG_OCTAVE:      cfg_reg.octave_shift <= cfg_data[2:0];
                default:         cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Handshake control between the input register and the chord register.
    assign is_last    = (idx_reg == chord_reg.count - 3'd1);
    assign out_fire   = chord_valid_reg && chord.ready;
    assign chord_done = out_fire && is_last;
    assign chord_load = in_valid_reg && (!chord_valid_reg || chord_done);
    assign req.ready  = !in_valid_reg || chord_load;
    assign in_fire    = req.valid && req.ready;

    // Chord construction from the registered degree.
    sdcg_chord_calc u_calc
    (
        .cfg    (cfg_reg),
        .degree (in_degree_reg),
        .chord  (chord_next)
    );

    // Note index within the chord being streamed.
    always_comb
    begin
        idx_next = idx_reg;
        if (chord_load)
        begin
            idx_next = 3'd0;
        end
        else if (out_fire)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            chord_valid_reg <= 1'b0;
            idx_reg         <= 3'd0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (chord_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (chord_load)
            begin
                chord_valid_reg <= 1'b1;
            end
            else if (chord_done)
            begin
                chord_valid_reg <= 1'b0;
            end
            idx_reg <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_degree_reg <= req.degree;
        end
        if (chord_load)
        begin
            chord_reg <= chord_next;
        end
    end

    // Output transaction.
    assign chord.valid = chord_valid_reg;
    assign chord.note  = chord_reg.note[idx_reg];
    assign chord.last  = is_last;

endmodule
